FILE: hdl/fhm_pkg.sv
// Shared types, constants and helper functions for the fire heat map step unit.
// No dependencies; used by hdl/fire_heat_map_step_unit.sv.
`default_nettype none

package fhm_pkg;

   // Register indexes of the configuration port.
   localparam logic [0:0] CSR_WIDTH_IDX  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT_IDX = 1'b1;

   // Reset values of the size registers.
   localparam int WIDTH_RESET  = 80;
   localparam int HEIGHT_RESET = 24;

   // Lower clamp limits of the size registers.
   localparam int WIDTH_MIN  = 3;
   localparam int HEIGHT_MIN = 2;

   localparam logic [7:0] FULL_HEAT = 8'd255;

   // Smallest heat that reaches each ramp step (heat * 10 / 255 >= step).
   localparam logic [7:0] RAMP_THRESH [1:10] = '{
      8'd26, 8'd51, 8'd77, 8'd102, 8'd128, 8'd153, 8'd179, 8'd204, 8'd230, 8'd255
   };

   // Kind of cell an accepted item refers to.
   typedef enum logic [1:0] {
      CELL_SEED,
      CELL_LEFT,
      CELL_INNER,
      CELL_RIGHT
   } cell_kind_type;

   // Control carried from the read stage to the update stage.
   typedef struct packed {
      cell_kind_type kind;
      logic          fuel_bit;
      logic [1:0]    cooling;
      logic          frame_end;
      logic          zero_a;     // read port A sees a cell that holds zero
      logic          zero_b;     // read port B sees a cell that holds zero
   } stage_type;

   function automatic logic [3:0] ramp_of(input logic [7:0] heat);
      logic [3:0] ramp;
      ramp = 4'd0;
      for (int k = 1; k <= 10; k++) begin
         if (heat >= RAMP_THRESH[k]) begin
            ramp = 4'(k);
         end
      end
      return ramp;
   endfunction

   function automatic logic [6:0] glyph_of(input logic [3:0] ramp);
      logic [6:0] code;
      case (ramp)
         4'd0:    code = 7'h20;  // ' '
         4'd1:    code = 7'h2E;  // '.'
         4'd2:    code = 7'h3A;  // ':'
         4'd3:    code = 7'h3B;  // ';'
         4'd4:    code = 7'h2B;  // '+'
         4'd5:    code = 7'h3D;  // '='
         4'd6:    code = 7'h78;  // 'x'
         4'd7:    code = 7'h58;  // 'X'
         4'd8:    code = 7'h24;  // '$'
         4'd9:    code = 7'h26;  // '&'
         default: code = 7'h40;  // '@'
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/fire_heat_map_step_unit.sv
// Fire heat map step unit: one heat map cell per transfer, heat kept in an on-chip RAM.
// Depends on hdl/fhm_pkg.sv and hdl/fhm_heat_ram.sv.
// A result passes through the update stage register and then the output register.
// Throughput: one cell per cycle; only a held result on the output stalls the input.
// Reset: synchronous; loads the 80 by 24 map size and restarts the sweep at the bottom row.
// The RAM is not swept: in the first frame after a restart, rows not yet written read as zero.
`default_nettype none

module fire_heat_map_step_unit #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration write port
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   // Input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] fuel_bit, [2:1] cooling, [7:3] zero
   // Result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [6:0] column, [12:7] row, [20:13] heat_value,
                                         // [24:21] ramp_index, [31:25] glyph_code
   output logic             rsp_tlast    // frame_end
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ADDR_W = ROW_W + COL_W;

   localparam int W_RESET_LAST =
      ((fhm_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : fhm_pkg::WIDTH_RESET) - 1;
   localparam int H_RESET_LAST =
      ((fhm_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : fhm_pkg::HEIGHT_RESET) - 1;

   // Size registers, kept as the clamped index of the last column and row.
   logic [COL_W-1:0] w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;

   // Sweep position.
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             seed_ff;
   logic             first_ff;

   // Update stage.
   logic                s1_valid_ff;
   fhm_pkg::stage_type  s1_ff, s1_in;
   logic [COL_W-1:0]    s1_col_ff;
   logic [ROW_W-1:0]    s1_row_ff;

   // Window of the row below: cells at column-1 and column.
   logic [7:0] win_prev_ff;
   logic [7:0] win_cur_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_last_ff;

   logic             accept;
   logic             advance;
   logic             cfg_restart;
   logic             cell_last_col;
   logic             cell_last_row;
   logic [ROW_W-1:0] cur_row;
   logic [ROW_W-1:0] below_row;
   logic [COL_W-1:0] next_col;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [7:0]       rd_data_a;
   logic [7:0]       rd_data_b;
   logic [7:0]       cell_a;
   logic [7:0]       cell_b;
   logic [9:0]       sum;
   logic [7:0]       avg;
   logic [7:0]       heat;
   logic [3:0]       ramp;
   logic             wr_en;

   // ---------------------------------------------------------------- config
   always_comb begin
      if (csr_wdata < 8'(fhm_pkg::WIDTH_MIN)) begin
         w_last_in = COL_W'(fhm_pkg::WIDTH_MIN - 1);
      end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
         w_last_in = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last_in = COL_W'(csr_wdata - 8'd1);
      end
      if (csr_wdata[6:0] < 7'(fhm_pkg::HEIGHT_MIN)) begin
         h_last_in = ROW_W'(fhm_pkg::HEIGHT_MIN - 1);
      end else if (32'(csr_wdata[6:0]) > 32'(MAX_HEIGHT)) begin
         h_last_in = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last_in = ROW_W'(csr_wdata[6:0] - 7'd1);
      end
   end

   always_comb begin
      case (csr_index)
         fhm_pkg::CSR_WIDTH_IDX:  cfg_restart = csr_we;
         fhm_pkg::CSR_HEIGHT_IDX: cfg_restart = csr_we;
         default:                 cfg_restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= COL_W'(W_RESET_LAST);
         h_last_ff <= ROW_W'(H_RESET_LAST);
      end else if (csr_we) begin
         case (csr_index)
            fhm_pkg::CSR_WIDTH_IDX:  w_last_ff <= w_last_in;
            fhm_pkg::CSR_HEIGHT_IDX: h_last_ff <= h_last_in;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   assign advance    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign accept     = req_tvalid & req_tready;

   // ---------------------------------------------------------------- read stage
   assign cell_last_col = (col_ff == w_last_ff);
   assign cell_last_row = (row_ff == h_last_ff - ROW_W'(1));
   assign cur_row       = seed_ff ? h_last_ff : row_ff;
   assign below_row     = row_ff + ROW_W'(1);
   assign next_col      = col_ff + COL_W'(1);

   // Port A reads the cell below and to the right. Port B reads the cell itself, or at
   // the left edge the cell straight below so the window can be primed.
   assign rd_addr_a = {below_row, next_col};
   assign rd_addr_b = (col_ff == '0) ? {below_row, col_ff} : {row_ff, col_ff};

   // Edge columns above the bottom row are never written and are read as zero; in the first
   // frame after a restart no row above the bottom row has been written yet.
   always_comb begin
      s1_in           = '0;
      s1_in.fuel_bit  = req_tdata[0];
      s1_in.cooling   = req_tdata[2:1];
      if (seed_ff) begin
         s1_in.kind = fhm_pkg::CELL_SEED;
      end else if (col_ff == '0) begin
         s1_in.kind = fhm_pkg::CELL_LEFT;
      end else if (cell_last_col) begin
         s1_in.kind = fhm_pkg::CELL_RIGHT;
      end else begin
         s1_in.kind = fhm_pkg::CELL_INNER;
      end
      s1_in.frame_end = ~seed_ff & cell_last_col & cell_last_row;
      s1_in.zero_a    = ~cell_last_row & (first_ff | (next_col == w_last_ff));
      s1_in.zero_b    = (col_ff == '0) ? ~cell_last_row : first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         col_ff   <= '0;
         row_ff   <= '0;
         seed_ff  <= 1'b1;
         first_ff <= 1'b1;
      end else if (accept) begin
         if (cell_last_col) begin
            col_ff <= '0;
            if (seed_ff) begin
               seed_ff <= 1'b0;
               row_ff  <= '0;
            end else if (cell_last_row) begin
               seed_ff  <= 1'b1;
               row_ff   <= '0;
               first_ff <= 1'b0;
            end else begin
               row_ff <= below_row;
            end
         end else begin
            col_ff <= next_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff     <= s1_in;
         s1_col_ff <= col_ff;
         s1_row_ff <= cur_row;
      end
   end

   fhm_heat_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (8)
   ) u_heat_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   ({s1_row_ff, s1_col_ff}),
      .wr_data   (heat),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // ---------------------------------------------------------------- update stage
   assign cell_a = s1_ff.zero_a ? 8'd0 : rd_data_a;
   assign cell_b = s1_ff.zero_b ? 8'd0 : rd_data_b;
   assign sum    = 10'(win_prev_ff) + 10'(win_cur_ff) + 10'(cell_a) + 10'(cell_b);
   assign avg    = sum[9:2];

   always_comb begin
      heat  = 8'd0;
      wr_en = 1'b0;
      case (s1_ff.kind)
         fhm_pkg::CELL_SEED: begin
            heat  = s1_ff.fuel_bit ? fhm_pkg::FULL_HEAT : 8'd0;
            wr_en = advance;
         end
         fhm_pkg::CELL_INNER: begin
            heat  = (avg > 8'(s1_ff.cooling)) ? (avg - 8'(s1_ff.cooling)) : 8'd0;
            wr_en = advance;
         end
         default: begin
            heat = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         case (s1_ff.kind)
            fhm_pkg::CELL_LEFT: begin
               win_prev_ff <= cell_b;
               win_cur_ff  <= cell_a;
            end
            fhm_pkg::CELL_INNER: begin
               win_prev_ff <= win_cur_ff;
               win_cur_ff  <= cell_a;
            end
            default: ;
         endcase
      end
   end

   assign ramp = fhm_pkg::ramp_of(heat);

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {fhm_pkg::glyph_of(ramp), ramp, heat, 6'(s1_row_ff), 7'(s1_col_ff)};
         rsp_last_ff <= s1_ff.frame_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/fhm_heat_ram.sv
// Heat store: synchronous RAM with one write port and two registered read ports.
// No dependencies; instantiated by hdl/fire_heat_map_step_unit.sv.
`default_nettype none

module fhm_heat_ram #(
   parameter int ADDR_W = 13,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [DATA_W-1:0] rd_data_a,
   output logic      [DATA_W-1:0] rd_data_b
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire
